@@ hdl/ist_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the interval set table.
// No dependencies; every other file imports this package.
package ist_pkg;

	// Function codes on the input beat
	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;
	localparam logic [1:0] FUNC_SPARE  = 2'd3;

	// Status codes on the output beat
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_DUP     = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// Classified command handed from front to back
	typedef enum logic [1:0] {
		OP_ADD,
		OP_REMOVE,
		OP_QUERY,
		OP_REJECT
	} op_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BS_IDLE,
		BS_WALK,
		BS_FINISH,
		BS_PREP,
		BS_PLACE,
		BS_DONE
	} bstate_t;

	// Result handed to the output register
	typedef struct packed {
		logic [1:0] status;
		logic       hit;
	} res_t;

endpackage

@@ hdl/ist_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input beats, masks times, classifies the operation
// and holds up to two commands for the back end. Depends on ist_pkg.
module ist_front import ist_pkg::*; #(
	parameter int TW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    func,
	input  logic [31:0]   span_start,
	input  logic [31:0]   span_end,
	input  logic [31:0]   probe_time,
	output logic          cmd_valid,
	input  logic          cmd_pop,
	output op_t           cmd_op,
	output logic [TW-1:0] cmd_start,
	output logic [TW-1:0] cmd_end,
	output logic [TW-1:0] cmd_time
);

	localparam int IW = (TW < 32) ? TW : 32;

	logic [TW-1:0] s_m, e_m, t_m;
	op_t           op_c;
	logic          push;

	op_t           q_op_q    [2];
	logic [TW-1:0] q_start_q [2];
	logic [TW-1:0] q_end_q   [2];
	logic [TW-1:0] q_time_q  [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign s_m = TW'(span_start[IW-1:0]);
	assign e_m = TW'(span_end[IW-1:0]);
	assign t_m = TW'(probe_time[IW-1:0]);

	always_comb begin
		case (func)
			FUNC_ADD:    op_c = (e_m > s_m) ? OP_ADD : OP_REJECT;
			FUNC_REMOVE: op_c = (e_m > s_m) ? OP_REMOVE : OP_REJECT;
			FUNC_QUERY:  op_c = OP_QUERY;
			default:     op_c = OP_REJECT;
		endcase
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_op    = q_op_q[rp_q];
	assign cmd_start = q_start_q[rp_q];
	assign cmd_end   = q_end_q[rp_q];
	assign cmd_time  = q_time_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (cmd_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_op_q[wp_q]    <= op_c;
			q_start_q[wp_q] <= s_m;
			q_end_q[wp_q]   <= e_m;
			q_time_q[wp_q]  <= t_m;
		end
	end

endmodule

@@ hdl/ist_back.sv @@
`timescale 1ns / 1ps
// Back end: sequencer that walks the interval table one entry per cycle,
// places split pieces, and drives the output register. Depends on ist_pkg.
module ist_back import ist_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int TW      = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  op_t           cmd_op,
	input  logic [TW-1:0] cmd_start,
	input  logic [TW-1:0] cmd_end,
	input  logic [TW-1:0] cmd_time,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic          inside_res
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
	localparam logic [AW:0]   FULL_CNT = (AW+1)'(ENTRIES);

	bstate_t state_q, state_d;

	// table storage
	logic [TW-1:0] start_mem [ENTRIES];
	logic [TW-1:0] end_mem   [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [TW-1:0] rd_start_q, rd_end_q;

	// pieces split off by a remove
	logic [TW-1:0] pc_start_mem [ENTRIES];
	logic [TW-1:0] pc_end_mem   [ENTRIES];
	logic [TW-1:0] pd_start_q, pd_end_q;

	op_t           op_q;
	logic [TW-1:0] s_q, e_q, t_q;
	logic [AW-1:0] idx_q, idx_d;
	logic          dup_q, hit_q, found_q;
	logic [AW-1:0] free_q;
	logic [AW:0]   npc_q, pi_q, pi_d, ptr_q;
	res_t          res_q, res_d;
	logic          res_ld;

	// memory write controls
	logic          we_s, we_e, pc_we, v_set, v_clr;
	logic [AW-1:0] waddr;
	logic [TW-1:0] wd_s, wd_e;

	logic entry_v, rem_a, rem_b, last;

	assign entry_v = valid_q[idx_q];
	assign rem_a   = (s_q <= rd_start_q) && (e_q > rd_start_q);
	assign rem_b   = (s_q > rd_start_q) && (s_q < rd_end_q);
	assign last    = (idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BS_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		idx_d   = idx_q;
		pi_d    = pi_q;
		we_s    = 1'b0;
		we_e    = 1'b0;
		pc_we   = 1'b0;
		v_set   = 1'b0;
		v_clr   = 1'b0;
		waddr   = idx_q;
		wd_s    = e_q;
		wd_e    = s_q;
		res_d   = res_q;
		res_ld  = 1'b0;
		case (state_q)
			BS_IDLE: begin
				idx_d = '0;
				pi_d  = '0;
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = (cmd_op == OP_REJECT) ? BS_DONE : BS_WALK;
					res_d   = '{status: (cmd_op == OP_REJECT) ? ST_INVALID : ST_OK,
						hit: 1'b0};
				end
			end
			BS_WALK: begin
				idx_d = idx_q + AW'(1);
				if (op_q == OP_REMOVE && entry_v) begin
					if (rem_a) begin
						if (e_q >= rd_end_q)
							v_clr = 1'b1;
						else
							we_s = 1'b1;
					end else if (rem_b) begin
						we_e  = 1'b1;
						pc_we = (e_q < rd_end_q);
					end
				end
				if (last) begin
					case (op_q)
						OP_ADD:    state_d = BS_FINISH;
						OP_REMOVE: state_d = BS_PREP;
						default:   state_d = BS_DONE;
					endcase
				end
			end
			BS_FINISH: begin
				waddr = free_q;
				wd_s  = s_q;
				wd_e  = e_q;
				if (dup_q)
					res_d.status = ST_DUP;
				else if (!found_q)
					res_d.status = ST_FULL;
				else begin
					we_s  = 1'b1;
					we_e  = 1'b1;
					v_set = 1'b1;
				end
				state_d = BS_DONE;
			end
			BS_PREP: begin
				state_d = BS_PLACE;
			end
			BS_PLACE: begin
				waddr = ptr_q[AW-1:0];
				wd_s  = pd_start_q;
				wd_e  = pd_end_q;
				if (pi_q == npc_q) begin
					state_d = BS_DONE;
				end else if (ptr_q == FULL_CNT) begin
					res_d.status = ST_FULL;
					state_d      = BS_DONE;
				end else if (!valid_q[ptr_q[AW-1:0]]) begin
					we_s  = 1'b1;
					we_e  = 1'b1;
					v_set = 1'b1;
					pi_d  = pi_q + (AW+1)'(1);
				end
			end
			BS_DONE: begin
				if (!out_valid || !out_stall) begin
					res_ld  = 1'b1;
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// control and bookkeeping registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			out_valid <= 1'b0;
			idx_q     <= '0;
			pi_q      <= '0;
			npc_q     <= '0;
			ptr_q     <= '0;
			dup_q     <= 1'b0;
			hit_q     <= 1'b0;
			found_q   <= 1'b0;
			free_q    <= '0;
		end else begin
			idx_q <= idx_d;
			pi_q  <= pi_d;
			if (v_set)
				valid_q[waddr] <= 1'b1;
			if (v_clr)
				valid_q[waddr] <= 1'b0;
			if (res_ld)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			case (state_q)
				BS_IDLE: begin
					npc_q   <= '0;
					ptr_q   <= '0;
					dup_q   <= 1'b0;
					hit_q   <= 1'b0;
					found_q <= 1'b0;
				end
				BS_WALK: begin
					if (entry_v && rd_start_q == s_q && rd_end_q == e_q)
						dup_q <= 1'b1;
					if (entry_v && t_q >= rd_start_q && t_q <= rd_end_q)
						hit_q <= 1'b1;
					if (!entry_v && !found_q) begin
						found_q <= 1'b1;
						free_q  <= idx_q;
					end
					if (pc_we)
						npc_q <= npc_q + (AW+1)'(1);
				end
				BS_PLACE: begin
					if (pi_q != npc_q && ptr_q != FULL_CNT)
						ptr_q <= ptr_q + (AW+1)'(1);
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q <= cmd_op;
			s_q  <= cmd_start;
			e_q  <= cmd_end;
			t_q  <= cmd_time;
		end
		if (state_q == BS_WALK && op_q == OP_QUERY && last)
			res_q <= '{status: ST_OK,
				hit: hit_q || (entry_v && t_q >= rd_start_q && t_q <= rd_end_q)};
		else
			res_q <= res_d;
		if (res_ld) begin
			status     <= res_q.status;
			inside_res <= res_q.hit;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we_s)
			start_mem[waddr] <= wd_s;
		if (we_e)
			end_mem[waddr] <= wd_e;
		rd_start_q <= start_mem[idx_d];
		rd_end_q   <= end_mem[idx_d];
	end

	// piece memory
	always_ff @(posedge clk) begin
		if (pc_we) begin
			pc_start_mem[npc_q[AW-1:0]] <= e_q;
			pc_end_mem[npc_q[AW-1:0]]   <= rd_end_q;
		end
		pd_start_q <= pc_start_mem[pi_d[AW-1:0]];
		pd_end_q   <= pc_end_mem[pi_d[AW-1:0]];
	end

endmodule

@@ hdl/interval_set_table.sv @@
`timescale 1ns / 1ps
// Interval set table top level: front end (classify, 2-deep command queue) and back end.
// A beat is queued by the front end and popped by the back end, which walks the table;
// an add then finishes, a remove then places its split pieces, and a malformed beat skips
// the walk. The back end finishes one operation before it pops the next, while the front
// end can queue further beats; the one-entry-per-cycle table walk sets the beat rate.
// Reset clears all valid bits, the queue and the output valid flag at once.
module interval_set_table import ist_pkg::*; #(
	parameter int ENTRIES   = 16,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] span_start,
	input  logic [31:0] span_end,
	input  logic [31:0] probe_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        inside_res
);

	// command path between front and back
	logic                 cmd_valid, cmd_pop;
	op_t                  cmd_op;
	logic [TIME_BITS-1:0] cmd_start, cmd_end, cmd_time;

	// Front: masks times to TIME_BITS, flags malformed spans and
	// unknown functions as rejects, queues up to two commands.
	ist_front #(
		.TW(TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.span_start (span_start),
		.span_end   (span_end),
		.probe_time (probe_time),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd_op     (cmd_op),
		.cmd_start  (cmd_start),
		.cmd_end    (cmd_end),
		.cmd_time   (cmd_time)
	);

	// Back: walks every entry once per operation (rejects skip the walk); a remove then moves
	// its split pieces into the lowest free slots with a rising pointer.
	ist_back #(
		.ENTRIES (ENTRIES),
		.TW      (TIME_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd_op     (cmd_op),
		.cmd_start  (cmd_start),
		.cmd_end    (cmd_end),
		.cmd_time   (cmd_time),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.inside_res (inside_res)
	);

	// a hit can only come from a query, which always reports ok
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_res |-> status == ST_OK)
		else $error("inside_res set with non-ok status");

	// the output register never drops a beat that was not taken
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat lost under stall");

	// beats are refused only while the queue holds commands for the back end
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> cmd_valid)
		else $error("input stalled with empty command queue");

endmodule
